// ----- src/mmp_pkg.sv -----
// Shared types, codes and decode helpers for the MIDI message parser.
`timescale 1ns / 1ps

package mmp_pkg;

  // Event type codes on the result channel
  localparam logic [2:0] KIND_NOTE_OFF = 3'd0;
  localparam logic [2:0] KIND_NOTE_ON  = 3'd1;
  localparam logic [2:0] KIND_CTRL     = 3'd2;
  localparam logic [2:0] KIND_PROGRAM  = 3'd3;
  localparam logic [2:0] KIND_BEND     = 3'd4;
  localparam logic [2:0] KIND_SYSEX    = 3'd5;

  // Status byte high nibbles and system bytes
  localparam logic [3:0] STAT_NOTE_OFF = 4'h8;
  localparam logic [3:0] STAT_NOTE_ON  = 4'h9;
  localparam logic [3:0] STAT_CTRL     = 4'hB;
  localparam logic [3:0] STAT_PROGRAM  = 4'hC;
  localparam logic [3:0] STAT_BEND     = 4'hE;
  localparam logic [3:0] STAT_SYSTEM   = 4'hF;
  localparam logic [7:0] BYTE_SYSEX_START = 8'hF0;
  localparam logic [7:0] BYTE_SYSEX_END   = 8'hF7;

  // One result transaction
  typedef struct packed {
    logic [2:0] event_type;
    logic [3:0] channel;
    logic [6:0] data_first;
    logic [6:0] data_second;
    logic [3:0] byte_index;
    logic [4:0] byte_count;
    logic       last_of_run;
  } res_t;

  // Controller to datapath
  typedef struct packed {
    logic take;       // input transaction accepted this cycle
    logic emit_push;  // push one stored sysex byte as a result
    logic idx_inc;    // advance the sysex read index
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic emit_req;   // the byte on the input starts a sysex run
    logic can_push;   // output stage has room for one result
    logic emit_last;  // read index points at the last stored byte
  } sts_t;

  // Decode a channel status: {supported, kind}
  function automatic logic [3:0] kind_of(input logic [7:0] st);
    logic [3:0] res;
    res = 4'd0;
    unique case (st[7:4])
      STAT_NOTE_OFF: res = {1'b1, KIND_NOTE_OFF};
      STAT_NOTE_ON:  res = {1'b1, KIND_NOTE_ON};
      STAT_CTRL:     res = {1'b1, KIND_CTRL};
      STAT_PROGRAM:  res = {1'b1, KIND_PROGRAM};
      STAT_BEND:     res = {1'b1, KIND_BEND};
      default:       res = 4'd0;
    endcase
    return res;
  endfunction

endpackage

// ----- src/mmp_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module mmp_ram #(
  parameter int WIDTH = 7,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- src/mmp_dp.sv -----
// Datapath: byte parser state, sysex store, emit index and output skid stage.
`timescale 1ns / 1ps

module mmp_dp #(
  parameter int SYSEX_BYTES = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic [7:0]    in_rx_byte,
  input  mmp_pkg::cmd_t cmd,
  output mmp_pkg::sts_t sts,
  input  logic          out_ready,
  output logic          out_valid,
  output mmp_pkg::res_t out_res
);

  localparam int FW = $clog2(SYSEX_BYTES + 1);
  localparam int CW = (FW > 5) ? FW : 5;
  localparam int AW = $clog2(SYSEX_BYTES);

  // Parse phases
  localparam logic [1:0] PH_IDLE  = 2'd0;
  localparam logic [1:0] PH_DATA1 = 2'd1;
  localparam logic [1:0] PH_DATA2 = 2'd2;
  localparam logic [1:0] PH_SYSEX = 2'd3;

  logic [1:0]    phase_r, phase_nxt;
  logic [7:0]    rs_r, rs_nxt;
  logic [2:0]    kind_r, kind_nxt;
  logic [3:0]    chan_r, chan_nxt;
  logic [6:0]    held_r, held_nxt;
  logic [CW-1:0] fill_r, fill_nxt;
  logic          done_r, done_nxt;
  logic [CW-1:0] idx_r;

  logic [3:0]    rs_kind;
  logic [3:0]    b_kind;
  logic [2:0]    kind_eff;
  logic [3:0]    chan_eff;
  logic          emit_req;
  logic          res_push;
  logic          ram_we;
  mmp_pkg::res_t chan_res;
  mmp_pkg::res_t emit_res;
  mmp_pkg::res_t push_res;
  logic          push;
  logic [6:0]    ram_rdata;

  mmp_pkg::res_t out_r, skid_r;
  logic          out_v_r, skid_v_r;
  logic          take_out;

  assign rs_kind = mmp_pkg::kind_of(rs_r);
  assign b_kind  = mmp_pkg::kind_of(in_rx_byte);

  // Decode the input byte against the parse state
  always_comb begin
    phase_nxt = phase_r;
    rs_nxt    = rs_r;
    kind_nxt  = kind_r;
    chan_nxt  = chan_r;
    held_nxt  = held_r;
    fill_nxt  = fill_r;
    done_nxt  = done_r;
    emit_req  = 1'b0;
    res_push  = 1'b0;
    ram_we    = 1'b0;
    kind_eff  = (phase_r == PH_IDLE) ? rs_kind[2:0] : kind_r;
    chan_eff  = (phase_r == PH_IDLE) ? rs_r[3:0] : chan_r;
    chan_res  = '0;
    chan_res.event_type  = kind_r;
    chan_res.channel     = chan_r;
    chan_res.data_first  = held_r;
    chan_res.data_second = in_rx_byte[6:0];
    chan_res.last_of_run = 1'b1;
    if (in_rx_byte[7]) begin
      priority if (in_rx_byte[7:3] == 5'b11111) begin
        // real-time: leave state alone
      end else if (in_rx_byte == mmp_pkg::BYTE_SYSEX_START) begin
        rs_nxt    = '0;
        kind_nxt  = mmp_pkg::KIND_SYSEX;
        fill_nxt  = '0;
        done_nxt  = 1'b0;
        phase_nxt = PH_SYSEX;
      end else if (in_rx_byte == mmp_pkg::BYTE_SYSEX_END) begin
        rs_nxt = '0;
        if (phase_r == PH_SYSEX) begin
          phase_nxt = PH_IDLE;
          emit_req  = !done_r && (fill_r != '0);
        end
        done_nxt = 1'b0;
      end else if (in_rx_byte[7:4] == mmp_pkg::STAT_SYSTEM) begin
        rs_nxt    = '0;
        phase_nxt = PH_IDLE;
      end else begin
        rs_nxt = in_rx_byte;
        if (!b_kind[3]) begin
          phase_nxt = PH_IDLE;
        end else begin
          kind_nxt  = b_kind[2:0];
          chan_nxt  = in_rx_byte[3:0];
          phase_nxt = PH_DATA1;
        end
      end
    end else begin
      priority if (phase_r == PH_SYSEX) begin
        // store until full; the filling byte starts the run
        if (!done_r) begin
          ram_we   = 1'b1;
          fill_nxt = fill_r + CW'(1);
          if (fill_nxt == CW'(SYSEX_BYTES)) begin
            done_nxt = 1'b1;
            emit_req = 1'b1;
          end
        end
      end else if (phase_r == PH_DATA2) begin
        phase_nxt = PH_IDLE;
        res_push  = 1'b1;
      end else if (phase_r == PH_DATA1 || rs_kind[3]) begin
        // first data byte, possibly under running status
        kind_nxt = kind_eff;
        chan_nxt = chan_eff;
        held_nxt = in_rx_byte[6:0];
        if (kind_eff == mmp_pkg::KIND_PROGRAM) begin
          phase_nxt            = PH_IDLE;
          res_push             = 1'b1;
          chan_res.event_type  = kind_eff;
          chan_res.channel     = chan_eff;
          chan_res.data_first  = in_rx_byte[6:0];
          chan_res.data_second = '0;
        end else begin
          phase_nxt = PH_DATA2;
        end
      end else begin
        // data with no usable running status: drop
      end
    end
  end

  // Update parser state on each input transaction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      rs_r    <= '0;
      kind_r  <= '0;
      chan_r  <= '0;
      held_r  <= '0;
      fill_r  <= '0;
      done_r  <= 1'b0;
    end else if (cmd.take) begin
      phase_r <= phase_nxt;
      rs_r    <= rs_nxt;
      kind_r  <= kind_nxt;
      chan_r  <= chan_nxt;
      held_r  <= held_nxt;
      fill_r  <= fill_nxt;
      done_r  <= done_nxt;
    end
  end

  // Sysex read index: clear on input, advance per emitted byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
    end else if (cmd.take) begin
      idx_r <= '0;
    end else if (cmd.idx_inc) begin
      idx_r <= idx_r + CW'(1);
    end
  end

  mmp_ram #(
    .WIDTH (7),
    .DEPTH (SYSEX_BYTES)
  ) u_store (
    .clk   (clk),
    .we    (cmd.take && ram_we),
    .waddr (fill_r[AW-1:0]),
    .wdata (in_rx_byte[6:0]),
    .raddr (idx_r[AW-1:0]),
    .rdata (ram_rdata)
  );

  // Form one sysex byte result
  always_comb begin
    emit_res             = '0;
    emit_res.event_type  = mmp_pkg::KIND_SYSEX;
    emit_res.data_first  = ram_rdata;
    emit_res.byte_index  = idx_r[3:0];
    emit_res.byte_count  = fill_r[4:0];
    emit_res.last_of_run = sts.emit_last;
  end

  assign push     = (cmd.take && res_push) || cmd.emit_push;
  assign push_res = cmd.emit_push ? emit_res : chan_res;
  assign take_out = !out_v_r || out_ready;

  // Output register with skid entry
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (take_out) begin
      out_v_r  <= skid_v_r || push;
      skid_v_r <= 1'b0;
    end else if (push) begin
      skid_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (take_out) begin
      out_r <= skid_v_r ? skid_r : push_res;
    end else if (push) begin
      skid_r <= push_res;
    end
  end

  assign sts.emit_req  = emit_req;
  assign sts.can_push  = !skid_v_r;
  assign sts.emit_last = ((idx_r + CW'(1)) == fill_r);
  assign out_valid     = out_v_r;
  assign out_res       = out_r;

endmodule

// ----- src/mmp_ctrl.sv -----
// Controller: accepts bytes and sequences the read-out of a stored sysex run.
`timescale 1ns / 1ps

module mmp_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  mmp_pkg::sts_t sts,
  output mmp_pkg::cmd_t cmd
);

  localparam logic [1:0] S_RUN  = 2'd0;  // take bytes
  localparam logic [1:0] S_READ = 2'd1;  // address the store
  localparam logic [1:0] S_PUSH = 2'd2;  // hand read data to the output

  logic [1:0] state_r, state_nxt;

  // Next state and commands
  always_comb begin
    state_nxt     = state_r;
    in_ready      = 1'b0;
    cmd.take      = 1'b0;
    cmd.emit_push = 1'b0;
    cmd.idx_inc   = 1'b0;
    unique case (state_r)
      S_RUN: begin
        in_ready = sts.can_push;
        cmd.take = in_valid && sts.can_push;
        if (cmd.take && sts.emit_req) begin
          state_nxt = S_READ;
        end
      end
      S_READ: begin
        state_nxt = S_PUSH;
      end
      S_PUSH: begin
        if (sts.can_push) begin
          cmd.emit_push = 1'b1;
          if (sts.emit_last) begin
            state_nxt = S_RUN;
          end else begin
            cmd.idx_inc = 1'b1;
            state_nxt   = S_READ;
          end
        end
      end
      default: begin
        state_nxt = S_RUN;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_RUN;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ----- src/midi_message_parser_unit.sv -----
// Top level of the MIDI message parser with running status.
//
//  Channel | Direction | Ports                                           | Handshake
//  in      | input     | in_rx_byte                                      | in_valid/in_ready
//  out     | output    | out_event_type, out_channel, out_data_first,    | out_valid/out_ready
//          |           | out_data_second, out_byte_index,                |
//          |           | out_byte_count, out_last_of_run                 |
//
// Bytes are taken while in_ready is high; the taking edge registers a channel message result.
// A byte that ends or fills a sysex holds in_ready low while the stored bytes are read out
// one at a time through the single registered read port of the sysex store.
// An output skid entry lets one more byte in while a result waits; when it is full,
// in_ready drops until out_ready drains it.
// Reset is synchronous, active low; the sysex store needs no clearing pass.
`timescale 1ns / 1ps

module midi_message_parser_unit #(
  parameter int SYSEX_BYTES = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_rx_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [2:0] out_event_type,
  output logic [3:0] out_channel,
  output logic [6:0] out_data_first,
  output logic [6:0] out_data_second,
  output logic [3:0] out_byte_index,
  output logic [4:0] out_byte_count,
  output logic       out_last_of_run
);

  mmp_pkg::cmd_t cmd;
  mmp_pkg::sts_t sts;
  mmp_pkg::res_t res;

  mmp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  mmp_dp #(
    .SYSEX_BYTES (SYSEX_BYTES)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_rx_byte (in_rx_byte),
    .cmd        (cmd),
    .sts        (sts),
    .out_ready  (out_ready),
    .out_valid  (out_valid),
    .out_res    (res)
  );

  assign out_event_type  = res.event_type;
  assign out_channel     = res.channel;
  assign out_data_first  = res.data_first;
  assign out_data_second = res.data_second;
  assign out_byte_index  = res.byte_index;
  assign out_byte_count  = res.byte_count;
  assign out_last_of_run = res.last_of_run;

  // Block input while a sysex run is being read out
  a_run_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && sts.emit_req) |=> !in_ready)
    else $error("input accepted during sysex read-out");

  // Channel messages are single results with no sysex count
  a_chan_single: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_event_type != mmp_pkg::KIND_SYSEX)
      |-> (out_last_of_run && out_byte_count == 5'd0 && out_byte_index == 4'd0))
    else $error("channel result with sysex fields");

  // Sysex read-out only pushes when the skid entry is free
  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit_push |-> sts.can_push)
    else $error("sysex result pushed into a full output stage");

endmodule
